>>> rtl/assert_macros.svh
// Assertion macros used by the accumulator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HLA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define HLA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");
`else
`define HLA_ASSERT(name, prop)
`define HLA_ASSERT_ALWAYS(name, prop)
`endif

`endif

>>> rtl/hla_pkg.sv
// Shared types, constants and trig table functions for the Hough line accumulator.
`default_nettype none

package hla_pkg;

  localparam int unsigned THETA_BINS_DEF  = 180;
  localparam int unsigned RHO_BINS_DEF    = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 24;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam logic [7:0] PIXEL_VOTE = 8'd255;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] IMAGE_ORIGIN = 32'hC000_0000;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  localparam logic [1:0] CFG_THETA_ORIGIN = 2'd0;
  localparam logic [1:0] CFG_RHO_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_RHO_SCALE    = 2'd2;

  typedef struct packed {
    logic        theta_origin;
    logic [15:0] rho_offset;
    logic [23:0] rho_scale;
  } hla_cfg_t;

  // sin(pi/2 * u), u in Q0.30, result Q1.15 in [0, 32767]
  function automatic longint quarter_sine(input longint u);
    longint u2;
    longint acc;
    longint s;
    u2  = (u * u) / Q30_ONE;
    acc = -64'sd3864;
    acc = 64'sd172272 + (acc * u2) / Q30_ONE;
    acc = -64'sd5026995 + (acc * u2) / Q30_ONE;
    acc = 64'sd85569306 + (acc * u2) / Q30_ONE;
    acc = -64'sd693598668 + (acc * u2) / Q30_ONE;
    acc = 64'sd1686629713 + (acc * u2) / Q30_ONE;
    s   = (acc * u) / Q30_ONE;
    if (s < 0) begin
      s = 0;
    end else begin
      s = (s + 64'sd16384) / 64'sd32768;
      if (s > 64'sd32767) s = 64'sd32767;
    end
    return s;
  endfunction

  // sine of a phase in units of 2^-32 turn
  function automatic longint phase_sine(input logic [31:0] ph);
    longint r;
    longint mag;
    r = longint'({34'd0, ph[29:0]});
    if (ph[30]) mag = quarter_sine(Q30_ONE - r);
    else mag = quarter_sine(r);
    return ph[31] ? -mag : mag;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hla_rho_unit.sv
// Rho binning unit: one shared multiplier stepped through x*cos, y*sin and scaling.
`default_nettype none

module hla_rho_unit #(
  parameter int unsigned THETA_BINS = hla_pkg::THETA_BINS_DEF,
  parameter int unsigned RHO_BINS   = hla_pkg::RHO_BINS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire  [$clog2(THETA_BINS)-1:0]        theta_i,
  input  wire  signed [15:0]                   x_i,
  input  wire  signed [15:0]                   y_i,
  input  hla_pkg::hla_cfg_t                    cfg_i,
  output logic                                 done_o,
  output logic [$clog2(RHO_BINS)-1:0]          bin_o
);
  import hla_pkg::*;

  localparam int unsigned TW = $clog2(THETA_BINS);
  localparam int unsigned RW = $clog2(RHO_BINS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_XC   = 6'b000010,
    ST_YS   = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_SCL  = 6'b010000,
    ST_BIN  = 6'b100000
  } step_e;

  step_e step_q, step_d;

  logic signed [16:0] sin_tab [2][THETA_BINS];
  logic signed [16:0] cos_tab [2][THETA_BINS];

  for (genvar g = 0; g < THETA_BINS; g++) begin : g_tab
    localparam logic [31:0] PH = 32'((64'(g) << 31) / 64'(THETA_BINS - 1));
    assign sin_tab[0][g] = 17'(phase_sine(32'(PH + IMAGE_ORIGIN)));
    assign cos_tab[0][g] = 17'(phase_sine(32'(PH + IMAGE_ORIGIN + QUARTER_TURN)));
    assign sin_tab[1][g] = 17'(phase_sine(PH));
    assign cos_tab[1][g] = 17'(phase_sine(32'(PH + QUARTER_TURN)));
  end

  logic signed [16:0] sin_v, cos_v;
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] prod_q;
  logic signed [33:0] sum_q;
  logic               neg_q;
  logic [RW-1:0]      bin_q;
  logic               done_q;
  logic [23:0]        quot;
  logic [TW-1:0]      th;

  assign th    = theta_i;
  assign sin_v = sin_tab[cfg_i.theta_origin][th];
  assign cos_v = cos_tab[cfg_i.theta_origin][th];
  assign quot  = prod_q[58:35];

  always_comb begin
    mul_a = 34'(x_i);
    mul_b = 25'(cos_v);
    case (step_q)
      ST_YS: begin
        mul_a = 34'(y_i);
        mul_b = 25'(sin_v);
      end
      ST_SCL: begin
        mul_a = sum_q;
        mul_b = $signed({1'b0, cfg_i.rho_scale});
      end
      default: begin
        mul_a = 34'(x_i);
        mul_b = 25'(cos_v);
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    case (step_q)
      ST_IDLE: if (start_i) step_d = ST_XC;
      ST_XC:   step_d = ST_YS;
      ST_YS:   step_d = ST_SUM;
      ST_SUM:  step_d = ST_SCL;
      ST_SCL:  step_d = ST_BIN;
      ST_BIN:  step_d = ST_IDLE;
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == ST_BIN);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (step_q)
      ST_YS:  sum_q <= 34'(prod_q) + $signed({3'b000, cfg_i.rho_offset, 15'd0});
      ST_SUM: sum_q <= sum_q + 34'(prod_q);
      default: sum_q <= sum_q;
    endcase
    if (step_q == ST_SCL) neg_q <= sum_q[33];
    if (step_q == ST_BIN) begin
      if (neg_q) bin_q <= '0;
      else if (quot > 24'(RHO_BINS - 1)) bin_q <= RW'(RHO_BINS - 1);
      else bin_q <= RW'(quot);
    end
  end

  assign done_o = done_q;
  assign bin_o  = bin_q;

endmodule

`default_nettype wire

>>> rtl/hough_line_accumulator_core.sv
// Hough line accumulator: sequencer, vote store and stream ports.
//
// Input stream (s_axis): tuser carries the action (clear, accumulate, read),
// tdata the point coordinates, pixel value and the bin to read. Output stream
// (m_axis) carries one transfer per read: the count and its saturation flag.
// Configuration (cfg_*) must be written only while the block is idle; the block itself does not enforce this.
// Reset and every clear action start a clearing pass over all THETA_BINS*RHO_BINS
// entries (46080 by default) of the vote store, one entry a cycle, ready low.
// An accumulate of a pixel of 255 visits every theta bin in turn: the rho unit
// runs five steps of one multiplier used for x*cos, y*sin and scaling, then the
// bin handoff, and the store does a read-modify-write (S_RD, S_WR), so ready
// stays low from the input transfer until the last theta bin is written.
// Other pixels and unused actions leave the block ready. A read goes through
// S_RRD and S_ROUT into the output register, which holds the result while the
// receiver stalls, and the block goes back to ready as soon as it is loaded.
`default_nettype none

module hough_line_accumulator_core #(
  parameter int unsigned THETA_BINS  = hla_pkg::THETA_BINS_DEF,
  parameter int unsigned RHO_BINS    = hla_pkg::RHO_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = hla_pkg::COUNT_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // x_coord[15:0], y_coord[31:16], pixel_value[39:32], theta_bin[47:40], rho_bin[55:48]
  input  wire  [55:0] s_axis_tdata,
  // action[1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // bin_count[23:0], bin_saturated[24], zero fill [31:25]
  output logic [31:0] m_axis_tdata,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [23:0] cfg_wdata_i
);
  import hla_pkg::*;

  localparam int unsigned DEPTH = THETA_BINS * RHO_BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TW    = $clog2(THETA_BINS);
  localparam int unsigned RW    = $clog2(RHO_BINS);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_WR    = 7'b0010000,
    S_RRD   = 7'b0100000,
    S_ROUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  hla_cfg_t cfg_q;

  logic [AW-1:0]          clr_q;
  logic [TW-1:0]          k_q;
  logic [AW-1:0]          base_q;
  logic [AW-1:0]          addr_q;
  logic                   inrange_q;
  logic signed [15:0]     x_q, y_q;
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic [COUNT_WIDTH-1:0] out_cnt_q;
  logic                   out_sat_q;
  logic                   m_valid_q;

  logic                   in_xfer;
  logic                   rho_start;
  logic                   rho_done;
  logic [RW-1:0]          rho_bin;
  logic                   rd_sat;
  logic                   out_load;
  logic                   last_theta;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [7:0]             rd_t, rd_r;
  logic [31:0]            rd_idx;
  logic                   rd_ok;
  logic [31:0]            cnt_ext;
  action_e                act;

  assign act        = action_e'(s_axis_tuser);
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign rd_sat     = (rd_data_q == {COUNT_WIDTH{1'b1}});
  assign last_theta = (k_q == TW'(THETA_BINS - 1));
  assign out_load   = (state_q == S_ROUT) && (!m_valid_q || m_axis_tready);
  assign rd_t       = s_axis_tdata[47:40];
  assign rd_r       = s_axis_tdata[55:48];
  assign rd_ok      = (32'(rd_t) < 32'(THETA_BINS)) && (32'(rd_r) < 32'(RHO_BINS));
  assign rd_idx     = 32'(rd_t) * 32'(RHO_BINS) + 32'(rd_r);

  assign rho_start = (in_xfer && act == ACT_ACCUM && s_axis_tdata[39:32] == PIXEL_VOTE) ||
                     (state_q == S_WR && !last_theta);

  hla_rho_unit #(
    .THETA_BINS(THETA_BINS),
    .RHO_BINS  (RHO_BINS)
  ) u_rho (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(rho_start),
    .theta_i(k_q),
    .x_i    (x_q),
    .y_i    (y_q),
    .cfg_i  (cfg_q),
    .done_o (rho_done),
    .bin_o  (rho_bin)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.theta_origin <= 1'b0;
      cfg_q.rho_offset   <= 16'd0;
      cfg_q.rho_scale    <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THETA_ORIGIN: cfg_q.theta_origin <= cfg_wdata_i[0];
        CFG_RHO_OFFSET:   cfg_q.rho_offset   <= cfg_wdata_i[15:0];
        CFG_RHO_SCALE:    cfg_q.rho_scale    <= cfg_wdata_i;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          case (act)
            ACT_CLEAR: state_d = S_CLEAR;
            ACT_ACCUM: if (rho_start) state_d = S_CALC;
            ACT_READ:  state_d = S_RRD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CALC:  if (rho_done) state_d = S_RD;
      S_RD:    state_d = S_WR;
      S_WR:    state_d = last_theta ? S_IDLE : S_CALC;
      S_RRD:   state_d = S_ROUT;
      S_ROUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      k_q       <= '0;
      base_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= AW'(clr_q + 1'b1);
      else clr_q <= '0;
      if (state_q == S_IDLE) begin
        k_q    <= '0;
        base_q <= '0;
      end else if (state_q == S_WR && !last_theta) begin
        k_q    <= TW'(k_q + 1'b1);
        base_q <= AW'(base_q + AW'(RHO_BINS));
      end
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q       <= s_axis_tdata[15:0];
      y_q       <= s_axis_tdata[31:16];
      inrange_q <= rd_ok;
      addr_q    <= AW'(rd_idx);
    end else if (state_q == S_CALC && rho_done) begin
      addr_q <= AW'(base_q + AW'(rho_bin));
    end
    if (out_load) begin
      out_cnt_q <= inrange_q ? rd_data_q : '0;
      out_sat_q <= inrange_q && rd_sat;
    end
  end

  // vote store: one write and one registered read per cycle
  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WR && !rd_sat);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : COUNT_WIDTH'(rd_data_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[addr_q];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign cnt_ext       = 32'(out_cnt_q);
  assign m_axis_tdata  = {7'd0, out_sat_q, cnt_ext[23:0]};

`include "assert_macros.svh"

  `HLA_ASSERT(a_done_in_calc, rho_done |-> state_q == S_CALC)
  `HLA_ASSERT(a_theta_range, (state_q == S_CALC) |-> (32'(k_q) < 32'(THETA_BINS)))
  `HLA_ASSERT(a_out_from_read, $rose(m_axis_tvalid) |-> $past(state_q == S_ROUT))
  `HLA_ASSERT_ALWAYS(a_clear_not_ready, (state_q == S_CLEAR) |-> !s_axis_tready)

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the Hough line accumulator core.
`timescale 1ns / 1ps

module tb;
  import hla_pkg::*;

  localparam int unsigned NTHETA = THETA_BINS_DEF;
  localparam int unsigned NRHO   = RHO_BINS_DEF;
  localparam int unsigned NSTORE = NTHETA * NRHO;
  localparam logic [23:0] COUNT_FULL = 24'hFF_FFFF;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  class vote_scoreboard;
    int unsigned votes[NSTORE];
    longint      cos_q15[NTHETA];
    longint      sin_q15[NTHETA];
    bit          origin_zero;
    logic [15:0] offset_q4;
    logic [23:0] scale_q16;
    logic [24:0] read_q[$];
    int unsigned hit_q[$];
    int          errors;

    function new();
      errors      = 0;
      origin_zero = 1'b0;
      offset_q4   = '0;
      scale_q16   = 24'd65536;
      wipe();
      build_trig();
    endfunction

    function void wipe();
      for (int i = 0; i < NSTORE; i++) votes[i] = 0;
    endfunction

    // sin(pi/2*u), u in Q0.30 -> Q1.15 clipped to [0,32767]
    function longint qsin(longint u);
      longint u2, a, s;
      u2 = (u * u) / 64'sd1073741824;
      a  = -64'sd3864;
      a  = 64'sd172272 + (a * u2) / 64'sd1073741824;
      a  = -64'sd5026995 + (a * u2) / 64'sd1073741824;
      a  = 64'sd85569306 + (a * u2) / 64'sd1073741824;
      a  = -64'sd693598668 + (a * u2) / 64'sd1073741824;
      a  = 64'sd1686629713 + (a * u2) / 64'sd1073741824;
      s  = (a * u) / 64'sd1073741824;
      if (s < 0) return 0;
      s = (s + 16384) / 32768;
      return (s > 32767) ? 64'sd32767 : s;
    endfunction

    function longint sin_turn(logic [31:0] p);
      longint rem, mag;
      rem = longint'(p[29:0]);
      mag = p[30] ? qsin(64'sd1073741824 - rem) : qsin(rem);
      return p[31] ? -mag : mag;
    endfunction

    function void build_trig();
      logic [63:0] wide;
      logic [31:0] ph;
      for (int k = 0; k < NTHETA; k++) begin
        wide = (64'(k) << 31) / 64'(NTHETA - 1);
        ph = wide[31:0];
        if (!origin_zero) ph = ph + IMAGE_ORIGIN;
        sin_q15[k] = sin_turn(ph);
        cos_q15[k] = sin_turn(ph + QUARTER_TURN);
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        CFG_THETA_ORIGIN: begin
          origin_zero = val[0];
          build_trig();
        end
        CFG_RHO_OFFSET: offset_q4 = val[15:0];
        CFG_RHO_SCALE:  scale_q16 = val;
        default: ;
      endcase
    endfunction

    function void cast(logic signed [15:0] x, logic signed [15:0] y);
      longint acc;
      logic [63:0] b;
      int unsigned idx;
      for (int k = 0; k < NTHETA; k++) begin
        acc = longint'(x) * cos_q15[k] + longint'(y) * sin_q15[k]
              + (longint'(offset_q4) <<< 15);
        if (acc < 0) b = 0;
        else b = (64'(acc) * 64'(scale_q16)) >> 35;
        if (b > NRHO - 1) b = NRHO - 1;
        idx = k * NRHO + int'(b);
        if (votes[idx] < COUNT_FULL) votes[idx]++;
        hit_q.push_back(idx);
        if (hit_q.size() > 720) void'(hit_q.pop_front());
      end
    endfunction

    function void note_input(logic [1:0] act, logic [55:0] d);
      logic [7:0] t, r;
      int unsigned c;
      t = d[47:40];
      r = d[55:48];
      case (act)
        ACT_CLEAR: wipe();
        ACT_ACCUM: if (d[39:32] == PIXEL_VOTE) cast(d[15:0], d[31:16]);
        ACT_READ: begin
          c = (t < NTHETA && r < NRHO) ? votes[t * NRHO + r] : 0;
          read_q.push_back({(c == COUNT_FULL), c[23:0]});
        end
        default: ;
      endcase
    endfunction

    function void check(logic [23:0] cnt, logic sat);
      logic [24:0] e;
      if (read_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: count %0d sat %0b", cnt, sat);
        return;
      end
      e = read_q.pop_front();
      if (e[23:0] !== cnt || e[24] !== sat) begin
        errors++;
        if (errors <= 10)
          $display("read mismatch: expected count %0d sat %0b, got count %0d sat %0b",
                   e[23:0], e[24], cnt, sat);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_wdata_i = '0;
  logic        rx_steady = 1'b0;

  vote_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  hough_line_accumulator_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls, with occasional stall-free stretches
  always @(negedge clk_i) begin
    if (rx_steady || $urandom_range(99) < 60) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) < 10) ? 1'b0 : ($urandom_range(1) == 1);
  end

  initial forever begin
    rx_steady = 1'b0;
    repeat ($urandom_range(200, 2000)) @(posedge clk_i);
    rx_steady = 1'b1;
    repeat ($urandom_range(200, 2000)) @(posedge clk_i);
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata[23:0], m_axis_tdata[24]);

  task automatic send(logic [1:0] act, logic [15:0] x, logic [15:0] y,
                      logic [7:0] pix, logic [7:0] t, logic [7:0] r);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tuser  = act;
    s_axis_tdata  = {r, t, pix, y, x};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(act, s_axis_tdata);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // a final read marks the phase end; once it returns the block is idle
  task automatic drain();
    send(ACT_READ, '0, '0, '0, 8'd0, 8'd0);
    idle_input();
    while (sb.read_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic rand_item();
    int p;
    int unsigned h;
    logic [15:0] x, y;
    p = int'($urandom_range(999));
    if (p < 3)
      send(ACT_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom));
    else if (p < 12)
      send(ACT_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom));
    else if (p < 400) begin
      if ($urandom_range(9) < 7) begin
        x = 16'($urandom_range(0, 4095));
        y = 16'($urandom_range(0, 4095));
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      send(ACT_ACCUM, x, y, ($urandom_range(9) == 0) ? 8'($urandom) : PIXEL_VOTE,
           8'($urandom), 8'($urandom));
    end else if (sb.hit_q.size() > 0 && $urandom_range(9) < 7) begin
      h = sb.hit_q[$urandom_range(sb.hit_q.size() - 1)];
      send(ACT_READ, 16'($urandom), 16'($urandom), 8'($urandom), 8'(h / NRHO),
           8'(h % NRHO));
    end else
      send(ACT_READ, 16'($urandom), 16'($urandom), 8'($urandom),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [23:0] cfgs[5][3];
    cfgs[0] = '{24'd1, 24'd0, 24'd65536};
    cfgs[1] = '{24'd0, 24'd65535, 24'hFF_FFFF};
    cfgs[2] = '{24'd1, 24'd32768, 24'd0};
    cfgs[3] = '{24'd0, 24'd8192, 24'd4096};
    cfgs[4] = '{24'd1, 24'd0, 24'd1_000_000};

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, all actions, ignored cases
    send(ACT_READ, '0, '0, '0, 8'd0, 8'd0);
    send(ACT_ACCUM, 16'h7FFF, 16'h7FFF, PIXEL_VOTE, 8'hFF, 8'hFF);
    send(ACT_ACCUM, 16'h8000, 16'h8000, PIXEL_VOTE, 8'h00, 8'h00);
    send(ACT_ACCUM, 16'h0000, 16'h0000, PIXEL_VOTE, 8'h00, 8'h00);
    send(ACT_ACCUM, 16'h0100, 16'h0200, 8'd254, 8'h00, 8'h00);
    send(ACT_ACCUM, 16'h0100, 16'h0200, 8'd0, 8'h00, 8'h00);
    send(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send(ACT_READ, '0, '0, '0, 8'd0, 8'd0);
    send(ACT_READ, '0, '0, '0, 8'd0, 8'd255);
    send(ACT_READ, '0, '0, '0, 8'd179, 8'd255);
    send(ACT_READ, '0, '0, '0, 8'd179, 8'd0);
    send(ACT_READ, 16'hFFFF, 16'hFFFF, 8'hFF, 8'd180, 8'd0);
    send(ACT_READ, '0, '0, '0, 8'd255, 8'd255);
    send(ACT_READ, '0, '0, '0, 8'd90, 8'd128);
    send(ACT_CLEAR, '0, '0, '0, '0, '0);
    send(ACT_READ, '0, '0, '0, 8'd0, 8'd0);
    send(ACT_READ, '0, '0, '0, 8'd179, 8'd255);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_THETA_ORIGIN, cfgs[ph][0]);
      write_reg(CFG_RHO_OFFSET, cfgs[ph][1]);
      write_reg(CFG_RHO_SCALE, cfgs[ph][2]);
      repeat (186) rand_item();
      drain();
    end

    if (sb.errors == 0 && sb.read_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/hla_pkg.sv
rtl/hla_rho_unit.sv
rtl/hough_line_accumulator_core.sv
tb/tb.sv
